// ===== rtl/qbse_pkg.sv =====
// quote book signal engine package: widths, reset values, register indexes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package qbse_pkg;
  localparam int SYMBOL_COUNT_DEF = 4;
  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int PRICE_W = 32;
  localparam int QTY_W = 16;
  localparam int SYM_W = 2;
  localparam int WIN_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_LIMIT0 = 3'd0;
  localparam logic [2:0] REG_LIMIT1 = 3'd1;
  localparam logic [2:0] REG_LIMIT2 = 3'd2;
  localparam logic [2:0] REG_LIMIT3 = 3'd3;
  localparam logic [2:0] REG_ENABLE = 3'd4;
  localparam logic [2:0] REG_BO_WIN = 3'd5;
  localparam logic [2:0] REG_SHORT_WIN = 3'd6;
  localparam logic [2:0] REG_LONG_WIN = 3'd7;

  localparam logic [31:0] LIMIT0_RST = 32'd52429;
  localparam logic [31:0] LIMIT1_RST = 32'd32768;
  localparam logic [31:0] LIMIT2_RST = 32'd45875;
  localparam logic [31:0] LIMIT3_RST = 32'd0;
  localparam logic [3:0] ENABLE_RST = 4'd7;
  localparam logic [4:0] BO_WIN_RST = 5'd10;
  localparam logic [4:0] SHORT_WIN_RST = 5'd3;
  localparam logic [4:0] LONG_WIN_RST = 5'd10;

  localparam logic [1:0] CROSS_NONE = 2'd0;
  localparam logic [1:0] CROSS_BUY = 2'd1;
  localparam logic [1:0] CROSS_SELL = 2'd2;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [PRICE_W-1:0] last_price;
    logic [PRICE_W-1:0] bid_price;
    logic [QTY_W-1:0] bid_size;
    logic [PRICE_W-1:0] ask_price;
    logic [QTY_W-1:0] ask_size;
  } quote_t;

  typedef struct packed {
    logic [PRICE_W-1:0] best_bid;
    logic [QTY_W-1:0] best_bid_qty;
    logic [PRICE_W-1:0] best_ask;
    logic [QTY_W-1:0] best_ask_qty;
    logic spread_signal;
    logic breakout_sell;
    logic breakout_buy;
    logic cross_buy;
    logic cross_sell;
  } signal_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;
endpackage
`default_nettype wire

// ===== rtl/qbse_if.sv =====
// valid/ready channel interface carrying one payload type
// depends on nothing; payload type given as a type parameter
`timescale 1ns / 1ps
`default_nettype none
interface qbse_if #(parameter type payload_t = logic) (input wire logic clk);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/quote_book_signal_engine.sv =====
// quote book signal engine top level: book, window ring, signal sequencer
// depends on qbse_pkg, qbse_if, qbse_ram
// each quote walks the ring through the one memory read port over the larger of n and l entries,
// n the breakout fill and l the long window
// a new quote is taken only after the previous result is loaded for output
// reset clears book, fill counts, heads, crossover history and registers;
// the ring needs no clearing since fill counts keep unwritten entries out of any result
`timescale 1ns / 1ps
`default_nettype none
module quote_book_signal_engine #(
  parameter int SYMBOL_COUNT = qbse_pkg::SYMBOL_COUNT_DEF,
  parameter int WINDOW_DEPTH = qbse_pkg::WINDOW_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  qbse_if.sink quote,
  qbse_if.sink cfg,
  qbse_if.source result
);
  import qbse_pkg::*;

  localparam int SW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int HW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam int AW = SW + HW;
  localparam int RAM_DEPTH = 2 ** AW;
  localparam int SUMW = PRICE_W + FW;
  localparam logic [FW-1:0] DEPTH_F = FW'(WINDOW_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_WALK, S_MUL, S_DONE} state_t;

  // configuration
  logic [PRICE_W-1:0] limit [4];
  logic [3:0] enable;
  logic [WIN_W-1:0] bo_win, short_win, long_win;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      limit[0] <= LIMIT0_RST; limit[1] <= LIMIT1_RST;
      limit[2] <= LIMIT2_RST; limit[3] <= LIMIT3_RST;
      enable <= ENABLE_RST; bo_win <= BO_WIN_RST;
      short_win <= SHORT_WIN_RST; long_win <= LONG_WIN_RST;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        REG_LIMIT0: limit[0] <= cfg.payload.data;
        REG_LIMIT1: limit[1] <= cfg.payload.data;
        REG_LIMIT2: limit[2] <= cfg.payload.data;
        REG_LIMIT3: limit[3] <= cfg.payload.data;
        REG_ENABLE: enable <= cfg.payload.data[3:0];
        REG_BO_WIN: bo_win <= cfg.payload.data[WIN_W-1:0];
        REG_SHORT_WIN: short_win <= cfg.payload.data[WIN_W-1:0];
        REG_LONG_WIN: long_win <= cfg.payload.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [FW-1:0] clamp_win(input logic [WIN_W-1:0] w);
    logic [31:0] wx;
    wx = 32'(w);
    if (wx == 32'd0) return FW'(1);
    if (wx > 32'(WINDOW_DEPTH)) return DEPTH_F;
    return FW'(wx);
  endfunction

  // symbol wrap by repeated compare and subtract
  function automatic logic [SW-1:0] wrap_sym(input logic [SYM_W-1:0] s);
    logic [31:0] v;
    v = 32'(s);
    for (int i = 0; i < 4; i++) begin
      if (v >= 32'(SYMBOL_COUNT)) v = v - 32'(SYMBOL_COUNT);
    end
    return SW'(v);
  endfunction

  // per-symbol small state
  logic [PRICE_W-1:0] bbid [SYMBOL_COUNT];
  logic [QTY_W-1:0] bbid_q [SYMBOL_COUNT];
  logic [PRICE_W-1:0] bask [SYMBOL_COUNT];
  logic [QTY_W-1:0] bask_q [SYMBOL_COUNT];
  logic [FW-1:0] bo_fill [SYMBOL_COUNT];
  logic [FW-1:0] av_fill [SYMBOL_COUNT];
  logic [HW-1:0] head [SYMBOL_COUNT];
  logic [1:0] prev [SYMBOL_COUNT];

  state_t state;
  quote_t q;
  logic [SW-1:0] sym;
  logic [FW-1:0] wb, wl, ws, nwalk, idx;
  logic [HW-1:0] h;
  logic [PRICE_W-1:0] lo, hi;
  logic [SUMW-1:0] sum_l, sum_s;
  logic [SUMW+FW-1:0] prod_a, prod_b;
  logic avg_full;
  logic rd_pending;
  logic [FW-1:0] rd_idx;
  signal_t res;
  logic res_valid;
  logic res_load;
  logic cx_buy, cx_sell;

  // window sizes and fill counts for the quote in work
  logic [FW-1:0] wb_c, wl_c, ws_c, nb_c, na_c;
  logic [31:0] bo_inc, av_inc;
  logic [HW-1:0] head_next;

  always_comb begin
    wb_c = clamp_win(bo_win);
    wl_c = clamp_win(long_win);
    ws_c = clamp_win(short_win);
    if (ws_c > wl_c) ws_c = wl_c;
    bo_inc = 32'(bo_fill[sym]) + 32'd1;
    av_inc = 32'(av_fill[sym]) + 32'd1;
    nb_c = (bo_inc > 32'(wb_c)) ? wb_c : FW'(bo_inc);
    na_c = (av_inc > 32'(wl_c)) ? wl_c : FW'(av_inc);
  end

  assign head_next = (head[sym] == HW'(WINDOW_DEPTH - 1)) ? '0 : HW'(head[sym] + HW'(1));

  // ring memory: both rings are the same data, kept in one memory
  logic ram_we;
  logic [AW-1:0] waddr, raddr;
  logic [PRICE_W-1:0] rdata;
  logic [HW-1:0] rpos;
  logic [31:0] rpos_x;

  always_comb begin
    rpos_x = 32'(h) + 32'(WINDOW_DEPTH) - 32'd1 - 32'(idx);
    if (rpos_x >= 32'(WINDOW_DEPTH)) rpos_x = rpos_x - 32'(WINDOW_DEPTH);
  end

  assign rpos = HW'(rpos_x);
  assign raddr = {sym, rpos};
  assign waddr = {sym, head[sym]};
  assign ram_we = (state == S_WRITE);

  qbse_ram #(.WIDTH(PRICE_W), .DEPTH(RAM_DEPTH)) u_ring (
    .clk(clk), .we(ram_we), .waddr(waddr), .wdata(q.last_price),
    .raddr(raddr), .rdata(rdata)
  );

  logic [SW-1:0] in_sym;
  assign in_sym = wrap_sym(quote.payload.symbol);
  assign quote.ready = (state == S_IDLE);
  assign result.valid = res_valid;
  assign result.payload = res;

  assign res_load = (state == S_DONE) && (!res_valid || result.ready);
  assign cx_buy = avg_full && (prod_a > prod_b) && (prev[sym] != CROSS_BUY);
  assign cx_sell = avg_full && !cx_buy && (prod_a < prod_b) && (prev[sym] != CROSS_SELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      rd_pending <= 1'b0;
      for (int s = 0; s < SYMBOL_COUNT; s++) begin
        bbid[s] <= '0; bbid_q[s] <= '0; bask[s] <= '1; bask_q[s] <= '0;
        bo_fill[s] <= '0; av_fill[s] <= '0; head[s] <= '0; prev[s] <= CROSS_NONE;
      end
    end else begin
      if (res_load) res_valid <= 1'b1;
      else if (result.valid && result.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (quote.valid) begin
            q <= quote.payload;
            sym <= in_sym;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          bo_fill[sym] <= nb_c;
          av_fill[sym] <= na_c;
          avg_full <= (av_inc >= 32'(wl_c));
          h <= head_next;
          head[sym] <= head_next;
          if (q.bid_price > bbid[sym]) begin
            bbid[sym] <= q.bid_price; bbid_q[sym] <= q.bid_size;
          end
          if (q.ask_price < bask[sym]) begin
            bask[sym] <= q.ask_price; bask_q[sym] <= q.ask_size;
          end
          nwalk <= (nb_c > wl_c) ? nb_c : wl_c;
          wb <= nb_c;
          wl <= wl_c;
          ws <= ws_c;
          idx <= '0;
          rd_pending <= 1'b0;
          lo <= '1; hi <= '0; sum_l <= '0; sum_s <= '0;
          state <= S_WALK;
        end
        S_WALK: begin
          rd_pending <= (idx < nwalk);
          rd_idx <= idx;
          if (idx < nwalk) idx <= idx + FW'(1);
          if (rd_pending) begin
            if (rd_idx < wb) begin
              if (rdata < lo) lo <= rdata;
              if (rdata > hi) hi <= rdata;
            end
            if (rd_idx < wl) sum_l <= sum_l + SUMW'(rdata);
            if (rd_idx < ws) sum_s <= sum_s + SUMW'(rdata);
          end
          if (!rd_pending && idx == nwalk && idx != '0) state <= S_MUL;
        end
        S_MUL: begin
          prod_a <= (SUMW+FW)'(sum_s) * (SUMW+FW)'(wl);
          prod_b <= (SUMW+FW)'(sum_l) * (SUMW+FW)'(ws);
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            res.best_bid <= bbid[sym];
            res.best_bid_qty <= bbid_q[sym];
            res.best_ask <= bask[sym];
            res.best_ask_qty <= bask_q[sym];
            res.spread_signal <= enable[2'(sym)] && (bask[sym] != '1) &&
                ((bask[sym] < bbid[sym]) || (bask[sym] - bbid[sym] <= limit[2'(sym)]));
            res.breakout_sell <= (wb > FW'(1)) && (q.last_price == hi);
            res.breakout_buy <= (wb > FW'(1)) && (q.last_price != hi) &&
                (q.last_price == lo);
            res.cross_buy <= cx_buy;
            res.cross_sell <= cx_sell;
            if (cx_buy) prev[sym] <= CROSS_BUY;
            else if (cx_sell) prev[sym] <= CROSS_SELL;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
      (quote.valid && quote.ready) |=> !quote.ready) else $error("overlap");
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
      $rose(res_valid) |-> $past(state == S_DONE)) else $error("stray result");
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
      (state == S_WALK) |-> (idx <= nwalk)) else $error("walk overrun");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
      (result.valid && !result.ready) |=> (result.valid && $stable(result.payload)))
      else $error("result changed while waiting");
endmodule
`default_nettype wire

// ===== rtl/qbse_ram.sv =====
// generic single-port write, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module qbse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
